// ----- src/vtm_pkg.sv -----
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types and constants for the virtual timer multiplexer.
// ----------------------------------------------------------------------------
package vtm_pkg;

	localparam int unsigned TW = 32;
	localparam logic [TW-1:0] NONE_DEADLINE = 32'hFFFF_FFFF;
	localparam logic [4:0] MAX_RES = 5'd16;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_START  = 2'd1,
		FN_CANCEL = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		K_STARTED   = 3'd0,
		K_FULL      = 3'd1,
		K_CANCELLED = 3'd2,
		K_IDLE_SLOT = 3'd3,
		K_EXPIRED   = 3'd4,
		K_QUIET     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE
	} state_t;

	typedef struct packed {
		func_t           func;
		logic [TW-1:0]   interval;
		logic            repeat_req;
		logic [3:0]      cancel_slot;
	} cmd_word_t;

	typedef struct packed {
		kind_t           kind;
		logic [3:0]      slot;
		logic [TW-1:0]   next_deadline;
		logic            last;
	} res_word_t;

	typedef struct packed {
		logic            done;
		logic            found;
		logic [TW-1:0]   deadline;
	} scan_res_t;

endpackage

// ----- src/vtm_ram.sv -----
// ----------------------------------------------------------------------------
// vtm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vtm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/vtm_scan.sv -----
// ----------------------------------------------------------------------------
// vtm_scan
// Sweeps the deadline memory one entry per cycle and keeps the earliest
// active deadline, lower slot on ties.
// ----------------------------------------------------------------------------
module vtm_scan #(
	parameter int unsigned NUM_TIMERS = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic [NUM_TIMERS-1:0]                             active,
	input  logic [vtm_pkg::TW-1:0]                            rdata,
	output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] raddr,
	output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] best_slot,
	output vtm_pkg::scan_res_t                                res
);

	localparam int unsigned SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [SW-1:0] LAST_IDX = SW'(NUM_TIMERS - 1);

	logic                   run_q;
	logic [SW-1:0]          idx_q;
	logic                   valid_s1;
	logic [SW-1:0]          slot_s1;
	logic                   found_q;
	logic                   done_q;
	logic [SW-1:0]          best_slot_q;
	logic [vtm_pkg::TW-1:0] best_dl_q;
	logic                   better;

	assign raddr  = idx_q;
	assign better = valid_s1 && active[slot_s1] && (!found_q || (rdata < best_dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else if (start) begin
			run_q    <= 1'b1;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= run_q;
			if (run_q) begin
				if (idx_q == LAST_IDX) begin
					run_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (better) begin
				found_q <= 1'b1;
			end
			if (valid_s1 && (slot_s1 == LAST_IDX)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (better) begin
			best_slot_q <= slot_s1;
			best_dl_q   <= rdata;
		end
	end

	assign best_slot    = best_slot_q;
	assign res.done     = done_q;
	assign res.found    = found_q;
	assign res.deadline = best_dl_q;

endmodule

// ----- src/virtual_timer_multiplexer_unit.sv -----
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer_unit
// Many one-shot or periodic virtual timers sharing one 32-bit tick counter.
// ----------------------------------------------------------------------------
// Deadlines and periods live in two memories; active and periodic flags are
// flip-flops. One command word is taken at a time. Every command but FN_NOP
// ends with a sweep of the deadline memory, one entry per cycle, to find the
// earliest pending deadline before its result word goes out; a tick that
// fires timers adds, for each expiry, a period read and write-back plus one
// further sweep, and the unit waits while the output register stays full.
// cmd_ready returns as soon as the last result word sits in the output
// register, which holds it until taken.
module virtual_timer_multiplexer_unit #(
	parameter int unsigned NUM_TIMERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  vtm_pkg::cmd_word_t cmd,
	output logic               result_valid,
	input  logic               result_ready,
	output vtm_pkg::res_word_t result
);

	localparam int unsigned SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	vtm_pkg::state_t        state_q, state_d;
	logic [vtm_pkg::TW-1:0] time_q;
	logic [NUM_TIMERS-1:0]  active_q;
	logic [NUM_TIMERS-1:0]  periodic_q;
	logic [4:0]             n_q;
	logic                   pend_q;
	logic                   tick_q;
	vtm_pkg::kind_t         kind_q;
	logic [3:0]             slot_q;
	logic                   out_valid_q;
	vtm_pkg::res_word_t     out_q;

	logic                   accept;
	logic                   out_free;
	logic                   emit;
	vtm_pkg::res_word_t     out_d;
	logic                   scan_start;
	logic                   fire;
	logic                   due;
	logic [vtm_pkg::TW-1:0] nxt;

	logic                   free_found;
	logic [SW-1:0]          free_idx;
	logic [SW-1:0]          cancel_idx;
	logic                   cancel_hit;

	logic                   dl_we;
	logic [SW-1:0]          dl_waddr;
	logic [vtm_pkg::TW-1:0] dl_wdata;
	logic [SW-1:0]          dl_raddr;
	logic [vtm_pkg::TW-1:0] dl_rdata;
	logic                   pr_we;
	logic [vtm_pkg::TW-1:0] pr_wdata;
	logic [vtm_pkg::TW-1:0] pr_rdata;

	logic [SW-1:0]          best_slot;
	vtm_pkg::scan_res_t     scan;

	vtm_ram #(.WIDTH(vtm_pkg::TW), .DEPTH(NUM_TIMERS)) u_deadline_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (dl_wdata),
		.raddr (dl_raddr),
		.rdata (dl_rdata)
	);

	vtm_ram #(.WIDTH(vtm_pkg::TW), .DEPTH(NUM_TIMERS)) u_period_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (free_idx),
		.wdata (pr_wdata),
		.raddr (best_slot),
		.rdata (pr_rdata)
	);

	vtm_scan #(.NUM_TIMERS(NUM_TIMERS)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.active    (active_q),
		.rdata     (dl_rdata),
		.raddr     (dl_raddr),
		.best_slot (best_slot),
		.res       (scan)
	);

	assign cmd_ready    = (state_q == vtm_pkg::ST_IDLE);
	assign accept       = cmd_valid && cmd_ready;
	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	assign cancel_idx = SW'(cmd.cancel_slot);
	assign cancel_hit = (7'(cmd.cancel_slot) < 7'(NUM_TIMERS)) && active_q[cancel_idx];

	assign due = scan.found && (scan.deadline < time_q) && (n_q < vtm_pkg::MAX_RES);
	assign nxt = scan.found ? scan.deadline : vtm_pkg::NONE_DEADLINE;

	assign pr_we    = accept && (cmd.func == vtm_pkg::FN_START) && free_found;
	assign pr_wdata = (cmd.repeat_req && (cmd.interval == '0)) ?
	                  {{(vtm_pkg::TW-1){1'b0}}, 1'b1} : cmd.interval;

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		out_d      = out_q;
		scan_start = 1'b0;
		fire       = 1'b0;
		dl_we      = 1'b0;
		dl_waddr   = free_idx;
		dl_wdata   = time_q + cmd.interval;
		case (state_q)
			vtm_pkg::ST_IDLE: begin
				if (accept && (cmd.func != vtm_pkg::FN_NOP)) begin
					scan_start = 1'b1;
					state_d    = vtm_pkg::ST_SCAN;
					dl_we      = pr_we;
				end
			end
			vtm_pkg::ST_SCAN: begin
				if (scan.done) begin
					if (tick_q && pend_q) begin
						if (out_free) begin
							emit               = 1'b1;
							out_d.kind         = vtm_pkg::K_EXPIRED;
							out_d.slot         = slot_q;
							out_d.next_deadline = nxt;
							out_d.last         = !due;
							state_d            = due ? vtm_pkg::ST_FIRE : vtm_pkg::ST_IDLE;
						end
					end else if (tick_q && due) begin
						state_d = vtm_pkg::ST_FIRE;
					end else if (out_free) begin
						emit               = 1'b1;
						out_d.kind         = tick_q ? vtm_pkg::K_QUIET : kind_q;
						out_d.slot         = tick_q ? 4'd0 : slot_q;
						out_d.next_deadline = nxt;
						out_d.last         = 1'b1;
						state_d            = vtm_pkg::ST_IDLE;
					end
				end
			end
			vtm_pkg::ST_FIRE: begin
				fire       = 1'b1;
				scan_start = 1'b1;
				dl_we      = periodic_q[best_slot];
				dl_waddr   = best_slot;
				dl_wdata   = scan.deadline + pr_rdata;
				state_d    = vtm_pkg::ST_SCAN;
			end
			default: begin
				state_d = vtm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			active_q    <= '0;
			periodic_q  <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			tick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				tick_q <= (cmd.func == vtm_pkg::FN_TICK);
				n_q    <= '0;
				pend_q <= 1'b0;
				case (cmd.func)
					vtm_pkg::FN_TICK: begin
						time_q <= time_q + 1'b1;
					end
					vtm_pkg::FN_START: begin
						if (free_found) begin
							active_q[free_idx]   <= 1'b1;
							periodic_q[free_idx] <= cmd.repeat_req;
						end
					end
					vtm_pkg::FN_CANCEL: begin
						if (cancel_hit) begin
							active_q[cancel_idx]   <= 1'b0;
							periodic_q[cancel_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (fire) begin
				n_q    <= n_q + 1'b1;
				pend_q <= 1'b1;
				if (!periodic_q[best_slot]) begin
					active_q[best_slot] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
		if (accept) begin
			case (cmd.func)
				vtm_pkg::FN_START: begin
					kind_q <= free_found ? vtm_pkg::K_STARTED : vtm_pkg::K_FULL;
					slot_q <= free_found ? 4'(free_idx) : 4'd0;
				end
				vtm_pkg::FN_CANCEL: begin
					kind_q <= cancel_hit ? vtm_pkg::K_CANCELLED : vtm_pkg::K_IDLE_SLOT;
					slot_q <= cmd.cancel_slot;
				end
				default: begin
					kind_q <= vtm_pkg::K_QUIET;
					slot_q <= 4'd0;
				end
			endcase
		end
		if (fire) begin
			slot_q <= 4'(best_slot);
		end
	end

`ifndef NO_ASSERTIONS
	a_fire_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vtm_pkg::ST_FIRE) |-> (scan.found && active_q[best_slot]))
		else $error("expiry of an idle slot");

	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vtm_pkg::ST_FIRE) |-> (n_q < vtm_pkg::MAX_RES))
		else $error("too many expiries in one tick");

	a_none_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (active_q == '0)) |-> (out_d.next_deadline == vtm_pkg::NONE_DEADLINE))
		else $error("next deadline reported with no active timer");

	a_quiet_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (out_d.kind == vtm_pkg::K_QUIET)) |-> (out_d.last && (n_q == '0)))
		else $error("quiet tick word not final");
`endif

endmodule
